@@ src/lifo_stack_with_search_unit_macros.svh @@
// Assertion macros for the LIFO stack with search unit
`ifndef LIFO_STACK_WITH_SEARCH_UNIT_MACROS_SVH
`define LIFO_STACK_WITH_SEARCH_UNIT_MACROS_SVH

`ifndef SYNTH
`define LSS_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);
`define LSS_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);
`define LSS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);
`else
`define LSS_ASSERT_ALWAYS(lbl, cond, msg)
`define LSS_ASSERT_IMPLIES(lbl, ante, cons, msg)
`define LSS_ASSERT_NEXT(lbl, ante, cons, msg)
`endif

`endif

@@ src/lss_pkg.sv @@
// Types and constants shared by the LIFO stack with search unit
package lss_pkg;

	localparam int unsigned DATA_W = 32;

	localparam logic [2:0] CMD_PUSH   = 3'd0;
	localparam logic [2:0] CMD_POP    = 3'd1;
	localparam logic [2:0] CMD_PEEK   = 3'd2;
	localparam logic [2:0] CMD_SEARCH = 3'd3;
	localparam logic [2:0] CMD_CLEAR  = 3'd4;

	localparam logic [1:0] STAT_OK    = 2'd0;
	localparam logic [1:0] STAT_FULL  = 2'd1;
	localparam logic [1:0] STAT_EMPTY = 2'd2;

	localparam logic signed [DATA_W-1:0] EMPTY_TOP = -32'sd27;

	typedef struct packed {
		logic [2:0]               cmd;
		logic signed [DATA_W-1:0] value;
	} lss_in_t;

	typedef struct packed {
		logic signed [DATA_W-1:0] top_value;
		logic                     found;
		logic                     is_empty;
		logic [6:0]               entry_total;
		logic [1:0]               status;
	} lss_out_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_POP,
		S_SEARCH
	} lss_state_t;

endpackage

@@ src/lifo_stack_with_search_unit.sv @@
// LIFO stack of signed 32-bit values with linear search, top level
// Usage:
//   Commands enter on in_valid/in_ready/in_data (cmd, value); every command
//   produces one result on out_valid/out_ready/out_data.
//   Entries live in one RAM of DEPTH words with a registered read;
//   the current top is also held in a register, and a fill count tracks depth.
//   Push, peek, clear and a pop that empties or underflows: result is
//   registered, valid in the cycle after the transfer; one such command per
//   cycle while out_ready is high. Pop leaving entries behind: the new top
//   passes the RAM read register and S_POP before the result register. Search:
//   walks the RAM from entry 0, one read per cycle, comparing each word with
//   the key until a hit or the last entry; an empty-stack search answers like a push.
//   A new command is taken only while no search or pop read is in flight and
//   the result register is empty or being drained in the same cycle; a stalled
//   receiver therefore holds off the input side.
//   Reset clears the fill count, the control state and the result valid; the
//   RAM contents are left as they are and are never read before written.
module lifo_stack_with_search_unit #(
	parameter int unsigned DEPTH = 64
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  lss_pkg::lss_in_t in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output lss_pkg::lss_out_t out_data
);

	import lss_pkg::*;

	`include "lifo_stack_with_search_unit_macros.svh"

	localparam int unsigned AW = $clog2(DEPTH);
	localparam int unsigned CW = $clog2(DEPTH + 1);

	lss_state_t               state_q, state_d;
	logic [CW-1:0]            cnt_q, cnt_d;
	logic [CW-1:0]            idx_q, idx_d;
	logic signed [DATA_W-1:0] top_q, top_d;
	logic signed [DATA_W-1:0] key_q, key_d;
	logic                     cmp_vld_s1, cmp_vld_d;
	logic                     last_s1, last_d;
	logic                     out_valid_q, out_valid_d;
	lss_out_t                 out_q, out_d;

	logic                     in_xfer;
	logic                     full;
	logic                     load;
	logic                     found_c;
	logic [1:0]               status_c;
	logic [CW-1:0]            cnt_m2;
	logic [CW+6:0]            cnt_ext;

	logic                     we;
	logic [AW-1:0]            waddr;
	logic [DATA_W-1:0]        wdata;
	logic                     re;
	logic [AW-1:0]            raddr;
	logic [DATA_W-1:0]        rdata;

	lss_ram #(
		.WIDTH(DATA_W),
		.DEPTH(DEPTH)
	) u_ram (
		.clk  (clk),
		.we   (we),
		.waddr(waddr),
		.wdata(wdata),
		.re   (re),
		.raddr(raddr),
		.rdata(rdata)
	);

	assign in_ready  = (state_q == S_IDLE) && (!out_valid_q || out_ready);
	assign in_xfer   = in_valid && in_ready;
	assign full      = (cnt_q == CW'(DEPTH));
	assign cnt_m2    = cnt_q - CW'(2);
	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	always_comb begin
		state_d     = state_q;
		cnt_d       = cnt_q;
		idx_d       = idx_q;
		top_d       = top_q;
		key_d       = key_q;
		cmp_vld_d   = 1'b0;
		last_d      = 1'b0;
		out_valid_d = out_valid_q && !out_ready;
		load        = 1'b0;
		found_c     = 1'b0;
		status_c    = STAT_OK;
		we          = 1'b0;
		waddr       = cnt_q[AW-1:0];
		wdata       = in_data.value;
		re          = 1'b0;
		raddr       = idx_q[AW-1:0];

		case (state_q)
			S_IDLE: begin
				if (in_xfer) begin
					case (in_data.cmd)
						CMD_PUSH: begin
							load = 1'b1;
							if (!full) begin
								we    = 1'b1;
								cnt_d = cnt_q + CW'(1);
								top_d = in_data.value;
							end else begin
								status_c = STAT_FULL;
							end
						end
						CMD_POP: begin
							if (cnt_q == '0) begin
								load     = 1'b1;
								status_c = STAT_EMPTY;
							end else if (cnt_q == CW'(1)) begin
								load  = 1'b1;
								cnt_d = '0;
							end else begin
								cnt_d   = cnt_q - CW'(1);
								re      = 1'b1;
								raddr   = cnt_m2[AW-1:0];
								state_d = S_POP;
							end
						end
						CMD_SEARCH: begin
							if (cnt_q == '0) begin
								load = 1'b1;
							end else begin
								key_d   = in_data.value;
								idx_d   = '0;
								state_d = S_SEARCH;
							end
						end
						CMD_CLEAR: begin
							load  = 1'b1;
							cnt_d = '0;
						end
						default: begin
							load = 1'b1;
						end
					endcase
				end
			end
			S_POP: begin
				top_d   = rdata;
				load    = 1'b1;
				state_d = S_IDLE;
			end
			S_SEARCH: begin
				if (idx_q < cnt_q) begin
					re        = 1'b1;
					idx_d     = idx_q + CW'(1);
					cmp_vld_d = 1'b1;
					last_d    = (idx_q == cnt_q - CW'(1));
				end
				if (cmp_vld_s1 && ((rdata == key_q) || last_s1)) begin
					found_c = (rdata == key_q);
					load    = 1'b1;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase

		cnt_ext              = {7'b0, cnt_d};
		out_d                = out_q;
		out_d.top_value      = (cnt_d == '0) ? EMPTY_TOP : top_d;
		out_d.found          = found_c;
		out_d.is_empty       = (cnt_d == '0);
		out_d.entry_total    = cnt_ext[6:0];
		out_d.status         = status_c;
		if (load) begin
			out_valid_d = 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			cnt_q       <= '0;
			idx_q       <= '0;
			cmp_vld_s1  <= 1'b0;
			last_s1     <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			cnt_q       <= cnt_d;
			idx_q       <= idx_d;
			cmp_vld_s1  <= cmp_vld_d;
			last_s1     <= last_d;
			out_valid_q <= out_valid_d;
		end
	end

	always_ff @(posedge clk) begin
		top_q <= top_d;
		key_q <= key_d;
		if (load) begin
			out_q <= out_d;
		end
	end

	`LSS_ASSERT_ALWAYS(a_cnt_bound, cnt_q <= CW'(DEPTH), "fill count exceeds depth")
	`LSS_ASSERT_IMPLIES(a_out_free, state_q != S_IDLE, !out_valid_q, "result held while busy")
	`LSS_ASSERT_NEXT(a_push_cnt, in_xfer && (in_data.cmd == CMD_PUSH) && !full, cnt_q == $past(cnt_q) + CW'(1), "push did not advance count")
	`LSS_ASSERT_NEXT(a_pop_wait, in_xfer && (in_data.cmd == CMD_POP) && (cnt_q > CW'(1)), state_q == S_POP, "pop skipped top read")

endmodule

@@ src/lss_ram.sv @@
// Generic simple dual-port RAM with registered read
module lss_ram #(
	parameter int unsigned WIDTH = 32,
	parameter int unsigned DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule
